// ----- rtl/core/ring_allocator_with_guard_headers_macros.svh -----
// Assertion helpers for the ring allocator.
`ifndef RING_ALLOCATOR_WITH_GUARD_HEADERS_MACROS_SVH
`define RING_ALLOCATOR_WITH_GUARD_HEADERS_MACROS_SVH

// Clocked check, disabled while reset is asserted (active low).
`define RAG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define RAG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/rag_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rag_pkg;

    // Field widths fixed by the interface
    localparam int ADDR_W        = 15;
    localparam int EXT_W         = 17;  // room for arena size plus block sums
    localparam int SEQ_W         = 32;
    localparam int GRANULE_BYTES = 16;
    localparam int GRAN_SHIFT    = 4;

    // Request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_CHECK = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_HDR_RANGE    = 3'd1,
        ST_BAD_SYNC     = 3'd2,
        ST_PREV_RANGE   = 3'd3,
        ST_PREV_SYNC    = 3'd4,
        ST_SEQ_MISMATCH = 3'd5,
        ST_TOO_LARGE    = 3'd6
    } t_status;

    // Placement of one allocate request
    typedef struct packed {
        logic              too_large;
        logic [EXT_W-1:0]  at;     // header offset
        logic [ADDR_W-1:0] next;   // working pointer after the block
    } t_place;

    // Round up to a whole granule
    function automatic logic [EXT_W-1:0] round_granule(input logic [EXT_W-1:0] v);
        logic [EXT_W-1:0] mask;
        mask = ~EXT_W'(GRANULE_BYTES - 1);
        return (v + EXT_W'(GRANULE_BYTES - 1)) & mask;
    endfunction

    // Effective arena size from the heap_bytes register
    function automatic logic [EXT_W-1:0] arena_of(input logic [ADDR_W-1:0] hb,
                                                  input int unsigned cap);
        logic [EXT_W-1:0] s;
        s = round_granule(EXT_W'(hb));
        if (s == '0) s = EXT_W'(GRANULE_BYTES);
        if (32'(s) > cap) s = EXT_W'(cap);
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rag_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rag_ram #(
    parameter int WIDTH = 43,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/rag_place.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rag_place (
    input  wire logic [rag_pkg::ADDR_W-1:0] i_request_size,
    input  wire logic [rag_pkg::ADDR_W-1:0] i_working_offset,
    input  wire logic [rag_pkg::EXT_W-1:0]  i_arena,
    output rag_pkg::t_place                 o_place
);
    import rag_pkg::*;

    logic [EXT_W-1:0] total;
    logic [EXT_W-1:0] sum;

    // Block size with header, and where it would end at the working pointer
    assign total = round_granule(EXT_W'(i_request_size)) + EXT_W'(GRANULE_BYTES);
    assign sum   = EXT_W'(i_working_offset) + total;

    // Bump, or wrap to the arena start when the end is reached or passed
    always_comb begin
        o_place.too_large = (total > i_arena);
        if (sum >= i_arena) begin
            o_place.at   = '0;
            o_place.next = (total >= i_arena) ? '0 : ADDR_W'(total);
        end else begin
            o_place.at   = EXT_W'(i_working_offset);
            o_place.next = ADDR_W'(sum);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ring_allocator_with_guard_headers.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Circular bump allocator with guard headers. An allocate transaction rounds
// its size up to 16 bytes, adds a 16-byte header, places the block at the
// working pointer (or at offset 0 when it would reach the arena end) and
// records the header in an on-chip header RAM; a block larger than the arena
// is refused. Results are registered, and wait in a hold register while the
// output register is full. A check transaction validates a body address: the
// address alone may reject it, else its own header is read, and the previous
// header after it when that must also be read, since the two header reads
// share the single registered read port of the header RAM. One request is
// worked on at a time; a new one is accepted while a finished result still
// waits in the output register. After reset and after every write of
// heap_bytes the header RAM is swept clear, one entry per cycle, through
// all HEAP_BYTES_MAX/16 entries (1024 by default), taking no requests.
module ring_allocator_with_guard_headers #(
    parameter int unsigned HEAP_BYTES_MAX = 16384
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [rag_pkg::ADDR_W-1:0]    i_cfg_wdata,
    // request channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_req_type,
    input  wire logic [rag_pkg::ADDR_W-1:0]    i_request_size,
    input  wire logic [rag_pkg::ADDR_W-1:0]    i_body_address,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [rag_pkg::ADDR_W-1:0]    o_granted_address,
    output logic                               o_ok,
    output logic      [2:0]                    o_status,
    output logic      [rag_pkg::SEQ_W-1:0]     o_sequence_given
);
    import rag_pkg::*;

    `include "ring_allocator_with_guard_headers_macros.svh"

    localparam int unsigned SLOT_COUNT = HEAP_BYTES_MAX / GRANULE_BYTES;
    localparam int          SLOT_W     = $clog2(SLOT_COUNT);
    localparam int          ENTRY_W    = 1 + SLOT_W + SEQ_W;

    // Header entry: used flag stands for the sync word
    typedef struct packed {
        logic              used;
        logic [SLOT_W-1:0] link;
        logic [SEQ_W-1:0]  seq;
    } t_entry;

    typedef struct packed {
        logic [ADDR_W-1:0] granted;
        t_status           status;
        logic [SEQ_W-1:0]  seq;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HDR,
        S_PRV,
        S_HOLD
    } t_state;

    t_state            r_state;
    logic              r_clearing;
    logic [SLOT_W-1:0] r_clr_addr;
    logic [EXT_W-1:0]  r_arena;
    logic [ADDR_W-1:0] r_working;
    logic [SEQ_W-1:0]  r_seq_cnt;
    logic [SLOT_W-1:0] r_prev_slot;
    logic [SEQ_W-1:0]  r_hdr_seq;
    t_result           r_hold;
    logic              r_out_valid;
    t_result           r_out;

    logic              in_fire;
    logic              out_free;
    logic              out_load;
    logic              alloc_ok;
    t_place            place;
    logic [EXT_W-1:0]  body;
    logic [EXT_W-1:0]  hdr;
    logic [SLOT_W-1:0] alloc_slot;
    logic [SLOT_W-1:0] chk_slot;
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    t_entry            ram_wdata;
    logic [SLOT_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry            q;
    logic              n_done;
    t_result           n_res;
    t_state            n_state;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign out_load = out_free && ((r_state == S_HOLD) || n_done);
    assign q        = t_entry'(ram_rdata);

    // Placement of an allocate transaction
    rag_place u_place (
        .i_request_size  (i_request_size),
        .i_working_offset(r_working),
        .i_arena         (r_arena),
        .o_place         (place)
    );

    assign alloc_ok   = in_fire && (i_req_type == REQ_ALLOC) && !place.too_large;
    assign alloc_slot = SLOT_W'(place.at >> GRAN_SHIFT);

    // Header address of a check
    assign body     = EXT_W'(i_body_address);
    assign hdr      = body - EXT_W'(GRANULE_BYTES);
    assign chk_slot = SLOT_W'(hdr >> GRAN_SHIFT);

    // Header RAM port control: clearing sweep owns the write port
    always_comb begin
        ram_we    = alloc_ok;
        ram_waddr = alloc_slot;
        ram_wdata = '{used: 1'b1, link: r_prev_slot, seq: r_seq_cnt};
        if (r_clearing) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end
        ram_raddr = (r_state == S_HDR) ? q.link : chk_slot;
    end

    rag_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SLOT_COUNT)
    ) u_hdr_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ENTRY_W'(ram_wdata)),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Request evaluation per state
    always_comb begin
        n_done  = 1'b0;
        n_res   = '{granted: '0, status: ST_OK, seq: '0};
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_done = 1'b1;
                    if (i_req_type == REQ_ALLOC) begin
                        if (place.too_large) begin
                            n_res.status = ST_TOO_LARGE;
                        end else begin
                            n_res.granted = ADDR_W'(place.at + EXT_W'(GRANULE_BYTES));
                            n_res.seq     = r_seq_cnt;
                        end
                    end else if (body < EXT_W'(GRANULE_BYTES) || hdr >= r_arena) begin
                        n_res.status = ST_HDR_RANGE;
                    end else if (hdr[GRAN_SHIFT-1:0] != '0) begin
                        n_res.status = ST_BAD_SYNC;
                    end else if (32'(hdr >> GRAN_SHIFT) >= SLOT_COUNT) begin
                        n_res.status = ST_HDR_RANGE;
                    end else begin
                        // header read issued this cycle
                        n_done  = 1'b0;
                        n_state = S_HDR;
                    end
                end
            end
            S_HDR: begin
                n_done = 1'b1;
                if (!q.used) begin
                    n_res.status = ST_BAD_SYNC;
                end else if (q.seq == '0) begin
                    n_res.status = ST_OK;
                end else if (32'(q.link) >= SLOT_COUNT ||
                             (32'(q.link) << GRAN_SHIFT) >= 32'(r_arena)) begin
                    n_res.status = ST_PREV_RANGE;
                end else begin
                    // previous header read issued this cycle
                    n_done  = 1'b0;
                    n_state = S_PRV;
                end
            end
            S_PRV: begin
                n_done = 1'b1;
                if (!q.used) begin
                    n_res.status = ST_PREV_SYNC;
                end else if (r_hdr_seq != q.seq + SEQ_W'(1)) begin
                    n_res.status = ST_SEQ_MISMATCH;
                end else begin
                    n_res.status = ST_OK;
                end
            end
            S_HOLD: begin
                n_res = r_hold;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, allocator registers, sweep and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_arena     <= arena_of(ADDR_W'(16384), HEAP_BYTES_MAX);
            r_working   <= '0;
            r_seq_cnt   <= '0;
            r_prev_slot <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result register loads a finished result, else drains
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == S_HOLD) begin
                if (out_free) begin
                    r_out   <= r_hold;
                    r_state <= S_IDLE;
                end
            end else if (n_done) begin
                if (out_free) begin
                    r_out   <= n_res;
                    r_state <= S_IDLE;
                end else begin
                    r_hold  <= n_res;
                    r_state <= S_HOLD;
                end
            end else begin
                r_state <= n_state;
            end

            // keep header sequence for the previous-header compare
            if (r_state == S_HDR) begin
                r_hdr_seq <= q.seq;
            end

            // commit an allocation
            if (alloc_ok) begin
                r_seq_cnt   <= r_seq_cnt + SEQ_W'(1);
                r_prev_slot <= alloc_slot;
            end

            // heap_bytes write: fresh arena; otherwise the pointer bumps
            if (i_cfg_we) begin
                r_arena   <= arena_of(i_cfg_wdata, HEAP_BYTES_MAX);
                r_working <= '0;
            end else if (alloc_ok) begin
                r_working <= place.next;
            end

            // clearing sweep, restarted by a heap_bytes write
            if (i_cfg_we) begin
                r_clearing <= 1'b1;
                r_clr_addr <= '0;
            end else if (r_clearing) begin
                r_clr_addr <= r_clr_addr + SLOT_W'(1);
                if (r_clr_addr == SLOT_W'(SLOT_COUNT - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    assign o_in_ready        = (r_state == S_IDLE) && !r_clearing;
    assign o_out_valid       = r_out_valid;
    assign o_granted_address = r_out.granted;
    assign o_status          = r_out.status;
    assign o_ok              = (r_out.status == ST_OK);
    assign o_sequence_given  = r_out.seq;

    // Assertions
    `RAG_ASSERT(a_fail_zero, i_clk, i_rst_n, (o_out_valid && !o_ok) |-> (o_granted_address == '0 && o_sequence_given == '0), "failed result carries address or sequence")
    `RAG_ASSERT(a_seq_step, i_clk, i_rst_n, ($past(i_rst_n) && (r_seq_cnt != $past(r_seq_cnt))) |-> $past(alloc_ok), "sequence counter moved without an allocation")
    `RAG_ASSERT(a_no_accept_clear, i_clk, i_rst_n, r_clearing |-> !in_fire, "request accepted during header sweep")
    `RAG_ASSERT_ALWAYS(a_work_in_arena, i_clk, !i_rst_n || (EXT_W'(r_working) < r_arena), "working pointer outside arena")

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import rag_pkg::*;

    localparam int          HEAP_CAP  = 16384;
    localparam int          SLOT_W    = 10;
    localparam int          SLOTS     = HEAP_CAP / GRANULE_BYTES;
    localparam logic [31:0] SYNC_WORD = 32'hAAAA_BBBB;
    localparam int          MAX_KEPT  = 24;

    // One response of the allocator
    typedef struct {
        logic [ADDR_W-1:0] granted;
        logic              ok;
        t_status           status;
        logic [SEQ_W-1:0]  seq;
    } arena_rsp_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [ADDR_W-1:0]    i_cfg_wdata;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_req_type;
    logic [ADDR_W-1:0]    i_request_size;
    logic [ADDR_W-1:0]    i_body_address;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [ADDR_W-1:0]    o_granted_address;
    logic                 o_ok;
    logic [2:0]           o_status;
    logic [SEQ_W-1:0]     o_sequence_given;

    // Shadow copy of the arena state
    logic [ADDR_W-1:0]    heap_reg;
    logic [ADDR_W-1:0]    work_ptr;
    logic [SEQ_W-1:0]     seq_next;
    logic [SLOT_W-1:0]    last_hdr_slot;
    logic [31:0]          hdr_sync [SLOTS];
    logic [31:0]          hdr_seq  [SLOTS];
    logic [SLOT_W-1:0]    hdr_link [SLOTS];

    arena_rsp_t           responses_due [$];
    arena_rsp_t           owed;
    logic [ADDR_W-1:0]    recent_bodies [$];

    int unsigned          send_idle_pct;
    int unsigned          recv_idle_pct;
    int unsigned          hold_request;
    int unsigned          hold_left;
    int unsigned          fail_count;
    int unsigned          n_sent;
    int unsigned          n_checked;
    int unsigned          n_configs;
    int unsigned          status_hits [8];

    ring_allocator_with_guard_headers #(
        .HEAP_BYTES_MAX (HEAP_CAP)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_req_type        (i_req_type),
        .i_request_size    (i_request_size),
        .i_body_address    (i_body_address),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_granted_address (o_granted_address),
        .o_ok              (o_ok),
        .o_status          (o_status),
        .o_sequence_given  (o_sequence_given)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest legal run
    initial begin
        #4_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // Fresh arena: pointer back to zero, every header slot cleared
    function automatic void clear_headers();
        work_ptr = '0;
        for (int s = 0; s < SLOTS; s++) begin
            hdr_sync[s] = '0;
            hdr_seq[s]  = '0;
            hdr_link[s] = '0;
        end
    endfunction

    // Arena size in bytes: granule-rounded, zero taken as one granule, capped
    function automatic logic [EXT_W-1:0] arena_now();
        logic [EXT_W-1:0] s;
        s = (EXT_W'(heap_reg) + EXT_W'(GRANULE_BYTES - 1)) & ~EXT_W'(GRANULE_BYTES - 1);
        if (s == '0) s = EXT_W'(GRANULE_BYTES);
        if (s > EXT_W'(HEAP_CAP)) s = EXT_W'(HEAP_CAP);
        return s;
    endfunction

    // Response of the arena to one request; updates the shadow state
    function automatic arena_rsp_t arena_step(input logic kind,
                                              input logic [ADDR_W-1:0] size,
                                              input logic [ADDR_W-1:0] body);
        arena_rsp_t        rsp;
        logic [EXT_W-1:0]  arena;
        logic [EXT_W-1:0]  blk;
        logic [EXT_W-1:0]  at;
        logic [EXT_W-1:0]  nxt;
        logic [EXT_W-1:0]  hdr;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] pslot;
        arena       = arena_now();
        rsp.granted = '0;
        rsp.seq     = '0;
        rsp.status  = ST_OK;
        if (kind == REQ_ALLOC) begin
            blk = ((EXT_W'(size) + EXT_W'(GRANULE_BYTES - 1)) & ~EXT_W'(GRANULE_BYTES - 1))
                  + EXT_W'(GRANULE_BYTES);
            if (blk > arena) begin
                rsp.status = ST_TOO_LARGE;
            end else begin
                at  = EXT_W'(work_ptr);
                nxt = at + blk;
                // reaching or passing the end wraps the block to offset zero
                if (nxt >= arena) begin
                    at  = '0;
                    nxt = blk;
                    if (nxt >= arena) nxt = '0;
                end
                work_ptr       = nxt[ADDR_W-1:0];
                slot           = at[GRAN_SHIFT +: SLOT_W];
                hdr_sync[slot] = SYNC_WORD;
                hdr_seq[slot]  = seq_next;
                hdr_link[slot] = last_hdr_slot;
                last_hdr_slot  = slot;
                rsp.seq        = seq_next;
                seq_next       = seq_next + 1'b1;   // 32-bit, wraps
                rsp.granted    = ADDR_W'(at + EXT_W'(GRANULE_BYTES));
            end
        end else if (body < ADDR_W'(GRANULE_BYTES)) begin
            rsp.status = ST_HDR_RANGE;
        end else begin
            hdr = EXT_W'(body) - EXT_W'(GRANULE_BYTES);
            if (hdr >= arena) begin
                rsp.status = ST_HDR_RANGE;
            end else if (hdr[GRAN_SHIFT-1:0] != '0) begin
                rsp.status = ST_BAD_SYNC;
            end else begin
                slot = hdr[GRAN_SHIFT +: SLOT_W];
                if (hdr_sync[slot] != SYNC_WORD) begin
                    rsp.status = ST_BAD_SYNC;
                end else if (hdr_seq[slot] != '0) begin
                    // not the first block: follow the link to the previous header
                    pslot = hdr_link[slot];
                    if ((EXT_W'(pslot) << GRAN_SHIFT) >= arena)
                        rsp.status = ST_PREV_RANGE;
                    else if (hdr_sync[pslot] != SYNC_WORD)
                        rsp.status = ST_PREV_SYNC;
                    else if (hdr_seq[slot] != hdr_seq[pslot] + 32'd1)
                        rsp.status = ST_SEQ_MISMATCH;
                end
            end
        end
        rsp.ok = (rsp.status == ST_OK);
        return rsp;
    endfunction

    // Result side: random stalls, plus long hold-offs on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else begin
                i_out_ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Compare each result transaction with the oldest one owed
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (responses_due.size() == 0) begin
                $error("tb: result transaction with none outstanding (status %0d)", o_status);
                fail_count++;
            end else begin
                owed = responses_due.pop_front();
                n_checked++;
                status_hits[owed.status]++;
                if (o_granted_address !== owed.granted) begin
                    $error("tb: granted_address expected %0d, got %0d",
                           owed.granted, o_granted_address);
                    fail_count++;
                end
                if (o_ok !== owed.ok) begin
                    $error("tb: ok expected %0d, got %0d", owed.ok, o_ok);
                    fail_count++;
                end
                if (o_status !== owed.status) begin
                    $error("tb: status expected %0d, got %0d", owed.status, o_status);
                    fail_count++;
                end
                if (o_sequence_given !== owed.seq) begin
                    $error("tb: sequence_given expected %0d, got %0d",
                           owed.seq, o_sequence_given);
                    fail_count++;
                end
            end
        end
    end

    // One request transaction; entered and left at a falling edge
    task automatic send_request(input logic kind, input logic [ADDR_W-1:0] size,
                                input logic [ADDR_W-1:0] body);
        arena_rsp_t rsp;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_req_type     = kind;
        i_request_size = size;
        i_body_address = body;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        rsp = arena_step(kind, size, body);
        responses_due.push_back(rsp);
        n_sent++;
        if (kind == REQ_ALLOC && rsp.ok) begin
            recent_bodies.push_back(rsp.granted);
            if (recent_bodies.size() > MAX_KEPT) void'(recent_bodies.pop_front());
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Wait until every owed result has arrived and the block has settled
    task automatic wait_quiet();
        while (responses_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // heap_bytes write, only with the block idle
    task automatic write_heap(input logic [ADDR_W-1:0] value);
        wait_quiet();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        heap_reg    = value;
        clear_headers();
        n_configs++;
    endtask

    // Fresh arena: two blocks, then both bodies checked
    task automatic test_alloc_and_check();
        send_request(REQ_ALLOC, 15'd0, 15'($urandom));
        send_request(REQ_ALLOC, 15'd17, 15'($urandom));
        send_request(REQ_CHECK, 15'($urandom), 15'd32);
        send_request(REQ_CHECK, 15'($urandom), 15'd16);
    endtask

    // Checks refused by the address alone or by a missing header
    task automatic test_check_rejects();
        send_request(REQ_CHECK, 15'($urandom), 15'd0);
        send_request(REQ_CHECK, 15'($urandom), 15'd15);
        send_request(REQ_CHECK, 15'($urandom), 15'h7FFF);
        send_request(REQ_CHECK, 15'($urandom), 15'd24);      // misaligned header
        send_request(REQ_CHECK, 15'($urandom), 15'd8000);    // never written
    endtask

    // Oversize requests, a block filling the whole arena, a self-linked header
    task automatic test_too_large_and_exact_fill();
        send_request(REQ_ALLOC, 15'h7FFF, 15'($urandom));
        send_request(REQ_ALLOC, 15'd16369, 15'($urandom));
        send_request(REQ_ALLOC, 15'd16368, 15'($urandom));
        send_request(REQ_CHECK, 15'($urandom), 15'd16);
        send_request(REQ_ALLOC, 15'd0, 15'($urandom));
        send_request(REQ_CHECK, 15'($urandom), 15'd16);
    endtask

    // Link kept across a shrink points outside the arena; wrap in a tiny arena
    task automatic test_link_across_shrink();
        send_request(REQ_ALLOC, 15'd8000, 15'($urandom));
        send_request(REQ_ALLOC, 15'd5000, 15'($urandom));
        write_heap(15'd100);
        send_request(REQ_ALLOC, 15'd40, 15'($urandom));
        send_request(REQ_CHECK, 15'($urandom), 15'd16);
        send_request(REQ_ALLOC, 15'd40, 15'($urandom));
        send_request(REQ_ALLOC, 15'd0, 15'($urandom));
        send_request(REQ_CHECK, 15'($urandom), 15'd80);
    endtask

    // Smallest arena, capped arena, and a link to a cleared header
    task automatic test_arena_extremes();
        write_heap(15'd0);
        send_request(REQ_ALLOC, 15'd0, 15'($urandom));
        send_request(REQ_ALLOC, 15'd1, 15'($urandom));
        write_heap(15'h7FFF);
        send_request(REQ_ALLOC, 15'd0, 15'($urandom));
        send_request(REQ_ALLOC, 15'd0, 15'($urandom));
        write_heap(15'd16384);
        send_request(REQ_ALLOC, 15'd0, 15'($urandom));
        send_request(REQ_CHECK, 15'($urandom), 15'd16);
    endtask

    // Mostly allocate-then-check traffic with random sizes, some noise
    task automatic run_mixed_traffic(input int unsigned count);
        int unsigned      done;
        int unsigned      r;
        logic [EXT_W-1:0] arena;
        logic [ADDR_W-1:0] size;
        done = 0;
        while (done < count) begin
            arena = arena_now();
            r     = $urandom_range(99);
            if (r < 45) begin
                r = $urandom_range(99);
                if (r < 70)      size = ADDR_W'($urandom_range(0, arena / 4));
                else if (r < 90) size = ADDR_W'($urandom_range(0, arena));
                else if (r < 97) size = 15'($urandom);
                else             size = ADDR_W'(arena - EXT_W'(GRANULE_BYTES));
                send_request(REQ_ALLOC, size, 15'($urandom));
                done++;
                if ($urandom_range(1) == 1 && recent_bodies.size() != 0) begin
                    send_request(REQ_CHECK, 15'($urandom), recent_bodies[$]);
                    done++;
                end
            end else if (r < 75 && recent_bodies.size() != 0) begin
                send_request(REQ_CHECK, 15'($urandom),
                             recent_bodies[$urandom_range(recent_bodies.size() - 1)]);
                done++;
            end else if (r < 88) begin
                send_request(REQ_CHECK, 15'($urandom),
                             ADDR_W'($urandom_range(0, arena / 16 + 1) * 16));
                done++;
            end else begin
                send_request(1'($urandom), 15'($urandom), 15'($urandom));
                done++;
            end
        end
    endtask

    // A few arena sizes, each with a share of mixed traffic
    task automatic test_random_traffic(input int unsigned per_size);
        logic [ADDR_W-1:0] sizes [7];
        sizes = '{15'd16, 15'd48, 15'd256, 15'd1000, 15'd4096, 15'd16384,
                  ADDR_W'($urandom_range(16, 16384))};
        repeat (3) begin
            write_heap(sizes[$urandom_range(6)]);
            run_mixed_traffic(per_size);
        end
    endtask

    // Results held off long enough that the block backs up into its input
    task automatic test_output_backpressure();
        int unsigned saved_idle;
        saved_idle    = send_idle_pct;
        send_idle_pct = 0;
        hold_request  = 300;
        run_mixed_traffic(20);
        wait_quiet();
        send_idle_pct = saved_idle;
        run_mixed_traffic(10);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_req_type     = REQ_ALLOC;
        i_request_size = '0;
        i_body_address = '0;
        i_out_ready    = 1'b0;
        hold_request   = 0;
        hold_left      = 0;
        fail_count     = 0;
        n_sent         = 0;
        n_checked      = 0;
        n_configs      = 0;
        foreach (status_hits[k]) status_hits[k] = 0;
        heap_reg       = 15'd16384;
        seq_next       = '0;
        last_hdr_slot  = '0;
        clear_headers();
        send_idle_pct  = 18;
        recv_idle_pct  = 62;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_alloc_and_check();
        test_check_rejects();
        test_too_large_and_exact_fill();
        test_link_across_shrink();
        test_arena_extremes();
        test_random_traffic(100);

        send_idle_pct = 62;
        recv_idle_pct = 18;
        test_random_traffic(100);
        test_output_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(100);

        wait_quiet();
        repeat (20) @(posedge i_clk);

        $display("tb: %0d requests, %0d results checked, %0d heap_bytes writes",
                 n_sent, n_checked, n_configs);
        $display("tb: results by status ok/hdr/sync/prev/prevsync/seq/large: %0d %0d %0d %0d %0d %0d %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], status_hits[5], status_hits[6]);
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
